>>> rtl/xcfr_pkg.sv
// ----------------------------------------------------------------------------
// xcfr_pkg
// Shared types and codes for the XOR-checked frame receiver.
// ----------------------------------------------------------------------------
package xcfr_pkg;

    localparam logic [7:0] MAX_LEN_RESET = 8'd64;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_LEN   = 2'd1;
    localparam logic [1:0] ST_BAD_CSUM  = 2'd2;
    localparam logic [1:0] ST_ZERO_RESP = 2'd3;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam int TDATA_W = 24;

    typedef enum logic [3:0] {
        PH_RESP = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_DATA = 4'b0100,
        PH_CSUM = 4'b1000
    } t_phase;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic [7:0] resp;
        logic [1:0] status;
        logic       last;
    } t_result;

endpackage

>>> rtl/xcfr_in_stage.sv
// ----------------------------------------------------------------------------
// xcfr_in_stage
// Input register for received bytes.
// ----------------------------------------------------------------------------
module xcfr_in_stage
    import xcfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

endmodule

>>> rtl/xcfr_parser.sv
// ----------------------------------------------------------------------------
// xcfr_parser
// Frame state machine: tracks phase, running XOR, remaining count and the
// response byte, and forms at most one result per byte.
// ----------------------------------------------------------------------------
module xcfr_parser
    import xcfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_advance,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_max_len,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_xor, n_xor;
    logic [7:0] r_left, n_left;
    logic [7:0] r_resp, n_resp;
    logic [7:0] xor_next;
    logic       len_bad;

    assign xor_next = r_xor ^ i_byte;
    assign len_bad  = (i_byte == 8'd0) || ({1'b0, i_byte} > ({1'b0, i_max_len} + 9'd1));

    always_comb begin
        n_phase     = r_phase;
        n_xor       = r_xor;
        n_left      = r_left;
        n_resp      = r_resp;
        o_res_valid = 1'b0;
        o_res       = '{kind: KIND_DATA, data: 8'd0, resp: r_resp, status: ST_OK,
                        last: 1'b0};
        if (i_advance) begin
            unique case (r_phase)
                PH_RESP: begin
                    n_resp  = i_byte;
                    n_xor   = i_byte;
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    if (len_bad) begin
                        o_res_valid  = 1'b1;
                        o_res.kind   = KIND_END;
                        o_res.status = ST_BAD_LEN;
                        o_res.last   = 1'b1;
                        n_phase      = PH_RESP;
                        n_xor        = 8'd0;
                        n_left       = 8'd0;
                    end else begin
                        n_xor   = xor_next;
                        n_left  = i_byte - 8'd1;
                        n_phase = (i_byte != 8'd1) ? PH_DATA : PH_CSUM;
                    end
                end
                PH_DATA: begin
                    o_res_valid = 1'b1;
                    o_res.data  = i_byte;
                    n_xor       = xor_next;
                    n_left      = r_left - 8'd1;
                    if (r_left == 8'd1) begin
                        n_phase = PH_CSUM;
                    end
                end
                PH_CSUM: begin
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_END;
                    o_res.last  = 1'b1;
                    if (i_byte != r_xor) begin
                        o_res.status = ST_BAD_CSUM;
                    end else if (r_resp == 8'd0) begin
                        o_res.status = ST_ZERO_RESP;
                    end else begin
                        o_res.status = ST_OK;
                    end
                    n_phase = PH_RESP;
                    n_xor   = 8'd0;
                    n_left  = 8'd0;
                end
                default: begin
                    n_phase = PH_RESP;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RESP;
            r_xor   <= 8'd0;
            r_left  <= 8'd0;
            r_resp  <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_xor   <= n_xor;
            r_left  <= n_left;
            r_resp  <= n_resp;
        end
    end

endmodule

>>> rtl/xcfr_out_stage.sv
// ----------------------------------------------------------------------------
// xcfr_out_stage
// Result register on the output stream.
// ----------------------------------------------------------------------------
module xcfr_out_stage
    import xcfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    output logic    o_free,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

>>> rtl/xor_checked_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// xor_checked_frame_receiver_unit
// Deframes length-prefixed frames closed by an XOR checksum byte.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one received byte per word on s_axis_tdata.
//   Master stream: one word per data byte, and one closing word per frame
//   with tlast high, tuser high and the frame status in tdata.
//   Frame: response byte, length byte (data count plus one), data bytes,
//   checksum byte equal to the XOR of all preceding frame bytes.
//   Response and good length bytes produce no word; a bad length closes the frame.
//   Config: i_cfg_we writes the max data count from i_cfg_wdata; write only
//   while the block is idle.
//   Path: the input register holds the byte; the result register holds its word.
//   Throughput: one byte per cycle while the result register is free; the
//   parser is combinational between the input register and the result register.
//   Stall: a held result keeps its word; an empty input register takes one more
//   byte, then s_axis_tready drops until the result leaves.
//   Reset: both registers empty, parser waits for a response byte, max data
//   count returns to 64.
// ----------------------------------------------------------------------------
module xor_checked_frame_receiver_unit
    import xcfr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] rx_byte
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // [7:0] out_byte, [15:8] response_code,
                                               // [17:16] frame_status, [23:18] zero
    output logic               m_axis_tuser,   // [0] out_kind
    output logic               m_axis_tlast
);

    logic [7:0] r_max_len;
    logic       in_valid;
    logic [7:0] in_byte;
    logic       out_free;
    logic       advance;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_wdata;
        end
    end

    assign advance = in_valid && out_free;

    xcfr_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_take  (advance),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    xcfr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_byte      (in_byte),
        .i_max_len   (r_max_len),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    xcfr_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_res   (out_res)
    );

    assign m_axis_tdata = {6'd0, out_res.status, out_res.resp, out_res.data};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

    a_last_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser))
        else $error("tlast and end kind disagree");

    a_data_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_DATA)) |-> (m_axis_tdata[17:16] == ST_OK))
        else $error("data word carries nonzero status");

    a_end_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_END)) |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("end word carries a data byte");

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_valid && !out_free) |=> (in_valid && $stable(in_byte)))
        else $error("held input byte lost during stall");

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the XOR-checked frame receiver. A byte driver and
// a word monitor run with random gaps and stalls. A local parser model
// predicts every result word. Traffic is mostly well-formed frames with
// random contents, plus bad lengths, bad checksums, zero responses and
// noise, across several max data count settings.
// ----------------------------------------------------------------------------
module tb;
    import xcfr_pkg::*;

    localparam int CLK_HALF        = 6;
    localparam int DRAIN_CYCLES    = 8;
    localparam int ITEMS_PER_PHASE = 235;
    localparam int LONG_HOLD       = 300;
    localparam int NUM_PHASES      = 7;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic [7:0]         i_cfg_wdata   = 8'h00;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata  = 8'h00;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic               m_axis_tuser;
    logic               m_axis_tlast;

    xor_checked_frame_receiver_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // parser model state
    t_phase     rx_phase    = PH_RESP;
    logic [7:0] rx_xor      = 8'h00;
    logic [7:0] rx_left     = 8'h00;
    logic [7:0] rx_resp     = 8'h00;
    logic [7:0] max_len_cfg = MAX_LEN_RESET;

    t_result    frame_results[$];
    t_result    next_result;
    logic [7:0] rx_bytes_pending[$];
    int         bytes_queued   = 0;
    int         bytes_taken    = 0;
    int         fail_count     = 0;

    int         send_gap       = 0;
    bit         send_burst     = 1'b0;
    int         recv_stall     = 0;
    bit         recv_burst     = 1'b0;
    bit         long_hold_req  = 1'b0;
    bit         long_hold_done = 1'b0;
    int         long_hold_left = 0;

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic void expect_word(logic kind, logic [7:0] data, logic [1:0] status);
        t_result r;
        r.kind   = kind;
        r.data   = data;
        r.resp   = rx_resp;
        r.status = status;
        r.last   = (kind == KIND_END);
        frame_results.push_back(r);
    endfunction

    function automatic void close_frame();
        rx_phase = PH_RESP;
        rx_xor   = 8'h00;
        rx_left  = 8'h00;
    endfunction

    function automatic void parse_rx_byte(logic [7:0] b);
        case (rx_phase)
            PH_RESP: begin
                rx_resp  = b;
                rx_xor   = b;
                rx_phase = PH_LEN;
            end
            PH_LEN: begin
                rx_xor = rx_xor ^ b;
                if (b == 8'h00 || {1'b0, b} > {1'b0, max_len_cfg} + 9'd1) begin
                    expect_word(KIND_END, 8'h00, ST_BAD_LEN);
                    close_frame();
                end else begin
                    rx_left  = b - 8'd1;
                    rx_phase = (rx_left != 8'h00) ? PH_DATA : PH_CSUM;
                end
            end
            PH_DATA: begin
                rx_xor = rx_xor ^ b;
                expect_word(KIND_DATA, b, ST_OK);
                rx_left = rx_left - 8'd1;
                if (rx_left == 8'h00) rx_phase = PH_CSUM;
            end
            default: begin
                if (b != rx_xor) expect_word(KIND_END, 8'h00, ST_BAD_CSUM);
                else if (rx_resp == 8'h00) expect_word(KIND_END, 8'h00, ST_ZERO_RESP);
                else expect_word(KIND_END, 8'h00, ST_OK);
                close_frame();
            end
        endcase
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // byte driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                parse_rx_byte(s_axis_tdata);
                bytes_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (rx_bytes_pending.size() > 0) begin
                    s_axis_tdata  <= rx_bytes_pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                    if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
                    send_gap = send_burst ? 0 : $urandom_range(0, 3);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // word monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (frame_results.size() == 0) begin
                    $error("word with no pending result: tdata %h tuser %b tlast %b",
                           m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    fail_count++;
                end else begin
                    next_result = frame_results.pop_front();
                    check_field("out_kind", next_result.kind, m_axis_tuser);
                    check_field("out_byte", next_result.data, m_axis_tdata[7:0]);
                    check_field("response_code", next_result.resp, m_axis_tdata[15:8]);
                    check_field("frame_status", next_result.status, m_axis_tdata[17:16]);
                    check_field("last_of_frame", next_result.last, m_axis_tlast);
                    check_field("tdata padding", 0, m_axis_tdata[TDATA_W-1:18]);
                end
                if ($urandom_range(0, 63) == 0) recv_burst = !recv_burst;
                recv_stall = recv_burst ? 0 : $urandom_range(0, 3);
            end
            if (long_hold_req && !long_hold_done) begin
                long_hold_done = 1'b1;
                long_hold_left = LONG_HOLD;
            end
            if (long_hold_left > 0) begin
                long_hold_left--;
                m_axis_tready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic queue_byte(input logic [7:0] b);
        rx_bytes_pending.push_back(b);
        bytes_queued++;
    endtask

    task automatic queue_frame(input logic [7:0] resp, input int ndata, input logic [7:0] flip);
        logic [7:0] sum;
        logic [7:0] b;
        queue_byte(resp);
        sum = resp;
        b = 8'(ndata + 1);
        queue_byte(b);
        sum = sum ^ b;
        repeat (ndata) begin
            b = 8'($urandom_range(0, 255));
            queue_byte(b);
            sum = sum ^ b;
        end
        queue_byte(sum ^ flip);
    endtask

    task automatic queue_random_traffic(input int n);
        int         first;
        int         pick;
        int         cap;
        int         nd;
        logic [7:0] resp;
        logic [7:0] flip;
        first = bytes_queued;
        cap = (max_len_cfg > 8'd254) ? 254 : max_len_cfg;
        while (bytes_queued - first < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                queue_byte(8'($urandom_range(0, 255)));
            end else if (pick < 14) begin
                queue_byte(8'($urandom_range(0, 255)));
                if (max_len_cfg >= 8'd254 || $urandom_range(0, 1) == 0) queue_byte(8'h00);
                else queue_byte(8'($urandom_range(max_len_cfg + 2, 255)));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 80) nd = $urandom_range(0, (cap < 6) ? cap : 6);
                else if (pick < 95) nd = $urandom_range(0, (cap < 40) ? cap : 40);
                else nd = cap;
                resp = ($urandom_range(0, 15) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
                flip = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
                queue_frame(resp, nd, flip);
            end
        end
    endtask

    task automatic wait_drained();
        while (bytes_taken != bytes_queued || frame_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_max_len(input logic [7:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        max_len_cfg = v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        int limits[NUM_PHASES];
        limits = '{0, 254, 255, 1, 0, 0, 64};
        limits[4] = $urandom_range(2, 253);
        limits[5] = $urandom_range(0, 254);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        queue_frame(8'hFF, 0, 8'h00);
        queue_frame(8'h00, 1, 8'h00);
        queue_frame(8'h00, 0, 8'h01);
        queue_frame(8'h81, 1, 8'h80);
        queue_byte(8'h5A);
        queue_byte(8'h00);
        queue_byte(8'h33);
        queue_byte(8'd66);
        queue_byte(8'hA5);
        queue_byte(8'hFF);
        queue_frame(8'h3C, 3, 8'h00);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_max_len(8'(limits[p]));
            queue_random_traffic(ITEMS_PER_PHASE);
            if (p == 1) long_hold_req = 1'b1;
            wait_drained();
        end

        if (fail_count == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

endmodule

>>> files.f
rtl/xcfr_pkg.sv
rtl/xcfr_in_stage.sv
rtl/xcfr_parser.sv
rtl/xcfr_out_stage.sv
rtl/xor_checked_frame_receiver_unit.sv
dv/tb.sv
